[sv/pli_pkg.sv]
`default_nettype none

package pli_pkg;

    // Default table depth.
    localparam int unsigned DEF_MAX_POINTS = 64;

    // Width of stored values and of the divider operands.
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned PROD_W   = 2 * VAL_W;
    localparam int unsigned DIV_STEPS = VAL_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Request kinds.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_VALUE  = 2'd0;
    localparam logic [1:0] ST_STORED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Control into the serial divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Status out of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[sv/pli_if.sv]
`default_nettype none

// Request channel: insert or query items.
interface pli_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;

    modport source (output valid, output req_type, output x_value, output y_value,
                    input ready);
    modport sink   (input valid, input req_type, input x_value, input y_value,
                    output ready);
endinterface

// Response channel: one result item per request item.
interface pli_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] y_result;
    logic        [1:0]  status;

    modport source (output valid, output y_result, output status, input ready);
    modport sink   (input valid, input y_result, input status, output ready);
endinterface

`default_nettype wire

[sv/piecewise_linear_interpolator.sv]
// Piecewise linear interpolation table. The block keeps up to MAX_POINTS
// breakpoints (x, y) in signed Q16.16, sorted by increasing x, in two
// single-port-read memories. An insert item (req_type 0) stores a new point in
// sorted position or overwrites y of an existing x; a new x on a full table is
// refused with status 3. A query item (req_type 1) returns y at an exact
// breakpoint, the end value outside the table, status 2 on an empty table, and
// otherwise y1 + trunc((x - x1) * (y2 - y1) / (x2 - x1)), saturated to 32 bits.
// One item is handled at a time and the request side is not ready meanwhile.
// Every item starts with a binary search in which each probe reads the middle
// slot (S_SRCH) and compares it with the key (S_SCMP); the slot that the
// search lands on is then read and checked (S_CHECK). An insert of a new x
// then moves each point above it up by one slot, reading it in S_SHRD and
// writing it in S_SHWR, and writes the new point in S_WNEW. A query that lands
// between breakpoints fetches the lower point (S_LOWER), forms one 32x33
// product (S_MUL) and starts a serial divider (S_DIVS) that yields one quotient
// bit per cycle, then collects the quotient (S_DIVW). Each item ends by handing
// its result over in S_DONE, after which the next item is taken in the idle
// state. The result sits in an output register, so the next item is taken
// while it still waits.

`default_nettype none

module piecewise_linear_interpolator #(
    parameter int unsigned MAX_POINTS = pli_pkg::DEF_MAX_POINTS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pli_req_if.sink   req,
    pli_rsp_if.source rsp
);
    import pli_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_POINTS);
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

    // One-hot sequencer states.
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SRCH  = 13'b0000000000010,
        S_SCMP  = 13'b0000000000100,
        S_CHECK = 13'b0000000001000,
        S_HOLD  = 13'b0000000010000,
        S_LOWER = 13'b0000000100000,
        S_MUL   = 13'b0000001000000,
        S_DIVS  = 13'b0000010000000,
        S_DIVW  = 13'b0000100000000,
        S_SHRD  = 13'b0001000000000,
        S_SHWR  = 13'b0010000000000,
        S_WNEW  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    // Breakpoint memories. Only entries below the point count are ever used.
    logic signed [VAL_W-1:0] point_x [MAX_POINTS];
    logic signed [VAL_W-1:0] point_y [MAX_POINTS];

    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        wr_addr;
    logic                    wr_en;
    logic signed [VAL_W-1:0] wr_x;
    logic signed [VAL_W-1:0] wr_y;
    logic signed [VAL_W-1:0] x_rd_reg;
    logic signed [VAL_W-1:0] y_rd_reg;

    state_t                  state_reg, state_next;
    logic                    type_reg, type_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] yin_reg, yin_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [CNT_W-1:0]        mid_reg, mid_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic signed [VAL_W-1:0] x2_reg, x2_next;
    logic signed [VAL_W-1:0] y2_reg, y2_next;
    logic signed [VAL_W-1:0] y1_reg, y1_next;
    logic [VAL_W-1:0]        dx_reg, dx_next;
    logic [VAL_W-1:0]        span_reg, span_next;
    logic [VAL_W:0]          mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [VAL_W-1:0] res_reg, res_next;
    logic [1:0]              stat_reg, stat_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_y_reg, out_y_next;
    logic [1:0]              out_stat_reg, out_stat_next;

    logic [CNT_W:0]          mid_sum;
    logic [CNT_W-1:0]        mid;
    logic [CNT_W-1:0]        k_dec;
    logic [CNT_W-1:0]        lo_dec;
    logic [CNT_W-1:0]        cnt_dec;
    logic                    hit;
    logic [VAL_W:0]          ydiff;
    logic [VAL_W+1:0]        sum;

    div_ctrl_t               div_ctrl;
    div_stat_t               div_stat;
    logic [VAL_W-1:0]        quotient;

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign k_dec   = k_reg - 1'b1;
    assign lo_dec  = lo_reg - 1'b1;
    assign cnt_dec = count_reg - 1'b1;
    // The probe read in the last search step was taken at the insertion slot.
    assign hit     = (lo_reg < count_reg) && (x_rd_reg == key_reg);
    assign ydiff   = {y2_reg[VAL_W-1], y2_reg} - {y_rd_reg[VAL_W-1], y_rd_reg};
    assign sum     = neg_reg ? ({{2{y1_reg[VAL_W-1]}}, y1_reg} - {2'b00, quotient})
                             : ({{2{y1_reg[VAL_W-1]}}, y1_reg} + {2'b00, quotient});

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.y_result = out_y_reg;
    assign rsp.status   = out_stat_reg;

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        key_next       = key_reg;
        yin_next       = yin_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        k_next         = k_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        y1_next        = y1_reg;
        dx_next        = dx_reg;
        span_next      = span_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        out_y_next     = out_y_reg;
        out_stat_next  = out_stat_reg;
        rd_addr        = '0;
        wr_addr        = '0;
        wr_en          = 1'b0;
        wr_x           = key_reg;
        wr_y           = yin_reg;
        div_ctrl.start = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    type_next  = req.req_type;
                    key_next   = req.x_value;
                    yin_next   = req.y_value;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid[IDX_W-1:0];
                    mid_next   = mid;
                    state_next = S_SCMP;
                end
                else
                begin
                    // Search finished: read the slot it landed on.
                    rd_addr    = (lo_reg < count_reg) ? lo_reg[IDX_W-1:0] : '0;
                    state_next = S_CHECK;
                end
            end
            S_SCMP:
            begin
                if (x_rd_reg < key_reg)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_CHECK:
            begin
                res_next = '0;
                if (type_reg == REQ_INSERT)
                begin
                    if (hit)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = lo_reg[IDX_W-1:0];
                        stat_next  = ST_STORED;
                        state_next = S_DONE;
                    end
                    else if (count_reg == CNT_W'(MAX_POINTS))
                    begin
                        stat_next  = ST_FULL;
                        state_next = S_DONE;
                    end
                    else if (count_reg > lo_reg)
                    begin
                        k_next     = count_reg;
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        state_next = S_WNEW;
                    end
                end
                else if (count_reg == '0)
                begin
                    stat_next  = ST_EMPTY;
                    state_next = S_DONE;
                end
                else if (hit || (lo_reg == '0))
                begin
                    // An exact hit or a point below the table: the probe read
                    // already holds the wanted y.
                    res_next   = y_rd_reg;
                    stat_next  = ST_VALUE;
                    state_next = S_DONE;
                end
                else if (lo_reg >= count_reg)
                begin
                    rd_addr    = cnt_dec[IDX_W-1:0];
                    state_next = S_HOLD;
                end
                else
                begin
                    x2_next    = x_rd_reg;
                    y2_next    = y_rd_reg;
                    rd_addr    = lo_dec[IDX_W-1:0];
                    state_next = S_LOWER;
                end
            end
            S_HOLD:
            begin
                res_next   = y_rd_reg;
                stat_next  = ST_VALUE;
                state_next = S_DONE;
            end
            S_LOWER:
            begin
                // Both differences are positive and below 2^32 because x
                // lies strictly between the two breakpoints.
                dx_next    = VAL_W'(key_reg - x_rd_reg);
                span_next  = VAL_W'(x2_reg - x_rd_reg);
                neg_next   = ydiff[VAL_W];
                mag_next   = ydiff[VAL_W] ? (~ydiff + 1'b1) : ydiff;
                y1_next    = y_rd_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(dx_reg * mag_reg);
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                div_ctrl.start = 1'b1;
                state_next     = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_stat.done)
                begin
                    if (sum[VAL_W+1:VAL_W-1] == 3'b000 || sum[VAL_W+1:VAL_W-1] == 3'b111)
                    begin
                        res_next = sum[VAL_W-1:0];
                    end
                    else
                    begin
                        res_next = sum[VAL_W+1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                : {1'b0, {(VAL_W-1){1'b1}}};
                    end
                    stat_next  = ST_VALUE;
                    state_next = S_DONE;
                end
            end
            S_SHRD:
            begin
                rd_addr    = k_dec[IDX_W-1:0];
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg[IDX_W-1:0];
                wr_x    = x_rd_reg;
                wr_y    = y_rd_reg;
                k_next  = k_dec;
                if (k_dec > lo_reg)
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    state_next = S_WNEW;
                end
            end
            S_WNEW:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[IDX_W-1:0];
                count_next = count_reg + 1'b1;
                stat_next  = ST_STORED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_y_next     = res_reg;
                    out_stat_next  = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            k_reg         <= '0;
            type_reg      <= REQ_INSERT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            k_reg         <= k_next;
            type_reg      <= type_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        yin_reg      <= yin_next;
        x2_reg       <= x2_next;
        y2_reg       <= y2_next;
        y1_reg       <= y1_next;
        dx_reg       <= dx_next;
        span_reg     <= span_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        out_y_reg    <= out_y_next;
        out_stat_reg <= out_stat_next;
    end

    // Breakpoint memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_x[wr_addr] <= wr_x;
            point_y[wr_addr] <= wr_y;
        end
        x_rd_reg <= point_x[rd_addr];
        y_rd_reg <= point_y[rd_addr];
    end

    // The table never holds more points than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count exceeds table depth");

    // The point count only changes when a new point is written.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == S_WNEW))
        else $error("point count changed outside a new-point write");

    // The divider answers only while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIVW))
        else $error("divider finished outside the wait state");

    // A started division keeps the divider busy in the next cycle.
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVS) |=> div_stat.busy)
        else $error("divider not busy after start");

    // A new result appears only when the sequencer hands one over.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == S_DONE))
        else $error("result valid rose outside the hand-over state");

endmodule

`default_nettype wire

[sv/pli_div.sv]
`default_nettype none

module pli_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pli_pkg::div_ctrl_t          ctrl,
    input  wire logic [pli_pkg::PROD_W-1:0]  dividend,
    input  wire logic [pli_pkg::VAL_W-1:0]   divisor,
    output      pli_pkg::div_stat_t          stat,
    output      logic [pli_pkg::VAL_W-1:0]   quotient
);
    import pli_pkg::*;

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // that the upper half of the dividend is below the divisor, so the
    // quotient fits in VAL_W bits.
    logic [VAL_W-1:0]     rem_reg, rem_next;
    logic [VAL_W-1:0]     quo_reg, quo_next;
    logic [VAL_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [VAL_W:0]       trial;
    logic                 qbit;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[VAL_W-1]};
        qbit      = (trial >= {1'b0, dvs_reg});
        if (ctrl.start)
        begin
            rem_next  = dividend[PROD_W-1:VAL_W];
            quo_next  = dividend[VAL_W-1:0];
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? VAL_W'(trial - {1'b0, dvs_reg}) : trial[VAL_W-1:0];
            quo_next = {quo_reg[VAL_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire
